// File: sv/ssr_pkg.sv
package ssr_pkg;

  typedef enum logic [2:0] {
    OP_SAMPLE       = 3'd0,
    OP_SWEEP_END    = 3'd1,
    OP_RESET_SURVEY = 3'd2,
    OP_CLEAR_EVENTS = 3'd3,
    OP_READ_OCC     = 3'd4,
    OP_READ_WF      = 3'd5,
    OP_READ_EVENT   = 3'd6
  } op_t;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_HOLDOFF   = 1'b1
  } cfg_reg_t;

  localparam logic [7:0]  THRESHOLD_RESET = 8'd60;
  localparam logic [15:0] HOLDOFF_RESET   = 16'd750;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ssr_state_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [6:0]  chan;
    logic [7:0]  lvl;
  } ev_rec_t;

  typedef struct packed {
    logic        take;
    logic        sweep;
    logic        clear;
    logic        read;
    logic [31:0] stamp;
    logic [6:0]  chan;
    logic [7:0]  lvl;
    logic [5:0]  age;
    logic [7:0]  threshold;
    logic [15:0] holdoff;
  } ev_cmd_t;

  typedef struct packed {
    logic    logged;
    logic    hit;
    ev_rec_t rec;
  } ev_res_t;

endpackage

// File: sv/ssr_ifs.sv
interface ssr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [6:0]  channel;
  logic [7:0]  level;
  logic [31:0] timestamp_ms;
  logic [6:0]  peak_channel;
  logic [7:0]  peak_level;
  logic [5:0]  age;

  modport source (output valid, operation, channel, level, timestamp_ms, peak_channel,
                  peak_level, age, input ready);
  modport sink (input valid, operation, channel, level, timestamp_ms, peak_channel,
                peak_level, age, output ready);
endinterface

interface ssr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic [6:0]  event_channel;
  logic [7:0]  event_level;
  logic        event_logged;
  logic [31:0] sweeps_done;
  logic [6:0]  rows_filled;
  logic [4:0]  events_held;

  modport source (output valid, read_value, event_channel, event_level, event_logged,
                  sweeps_done, rows_filled, events_held, input ready);
  modport sink (input valid, read_value, event_channel, event_level, event_logged,
                sweeps_done, rows_filled, events_held, output ready);
endinterface

interface ssr_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// File: sv/ssr_event_ring.sv
module ssr_event_ring #(
  parameter int EVENTS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ssr_pkg::ev_cmd_t           cmd,
  output ssr_pkg::ev_res_t           res,
  output logic [$clog2(EVENTS+1)-1:0] fill
);
  import ssr_pkg::*;

  localparam int EW  = $clog2(EVENTS);
  localparam int EFW = $clog2(EVENTS+1);

  ev_rec_t        mem [EVENTS];
  ev_rec_t        rd_rec;
  ev_rec_t        log_rec;
  logic [EW-1:0]  head;
  logic [31:0]    last_time;
  logic           logged_q;
  logic           hit_q;
  logic           do_log;
  logic [EW:0]    rd_sum;
  logic [EW-1:0]  rd_idx;

  // Logging needs the level at threshold and the hold-off elapsed, modulo 2^32.
  assign do_log = cmd.take && cmd.sweep && (cmd.lvl >= cmd.threshold) &&
                  ((cmd.stamp - last_time) >= 32'(cmd.holdoff));

  assign rd_sum = {1'b0, head} + (EW+1)'(EVENTS - 1) - {1'b0, EW'(cmd.age)};
  assign rd_idx = (rd_sum >= (EW+1)'(EVENTS)) ? EW'(rd_sum - (EW+1)'(EVENTS)) : EW'(rd_sum);

  always_ff @(posedge clk) begin
    if (do_log) begin
      mem[head] <= '{stamp: cmd.stamp, chan: cmd.chan, lvl: cmd.lvl};
    end
    if (cmd.take && cmd.read) begin
      rd_rec <= mem[rd_idx];
    end
    if (do_log) begin
      log_rec <= '{stamp: cmd.stamp, chan: cmd.chan, lvl: cmd.lvl};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      fill      <= '0;
      last_time <= '0;
      logged_q  <= 1'b0;
      hit_q     <= 1'b0;
    end else if (cmd.take) begin
      logged_q <= do_log;
      hit_q    <= cmd.read && (32'(cmd.age) < 32'(fill));
      if (cmd.clear) begin
        head      <= '0;
        fill      <= '0;
        last_time <= '0;
      end else if (do_log) begin
        head      <= (head == EW'(EVENTS - 1)) ? '0 : head + EW'(1);
        last_time <= cmd.stamp;
        if (fill < EFW'(EVENTS)) begin
          fill <= fill + EFW'(1);
        end
      end
    end
  end

  always_comb begin
    res.logged = logged_q;
    res.hit    = hit_q;
    if (logged_q) begin
      res.rec = log_rec;
    end else if (hit_q) begin
      res.rec = rd_rec;
    end else begin
      res.rec = '0;
    end
  end

endmodule

// File: sv/spectrum_survey_recorder.sv
// Channel | Dir | Word contents
// req     | in  | operation, channel, level, timestamp_ms, peak_channel, peak_level, age
// rsp     | out | read_value, event_channel, event_level, event_logged, counts
// cfg     | in  | addr (0 threshold, 1 hold-off), data
//
// Each word is handled at accept and then in the execute state: at accept the memory
// reads are issued and the ring pointers and counters updated; in the execute state the
// occupancy read-modify-write is done and the output register loaded (single-port
// occupancy memory). Reset is synchronous; occupancy entries carry valid bits, so no
// clearing pass is run. A finished word waits in the output register while one more
// word is accepted; that one then holds in execute until the output register frees up.
module spectrum_survey_recorder #(
  parameter int CHANNELS = 128,
  parameter int ROWS     = 64,
  parameter int EVENTS   = 16
) (
  input logic        clk,
  input logic        rst,
  ssr_req_if.sink    req,
  ssr_rsp_if.source  rsp,
  ssr_cfg_if.sink    cfg
);
  import ssr_pkg::*;

  localparam int CW       = $clog2(CHANNELS);
  localparam int RW       = $clog2(ROWS);
  localparam int FW       = $clog2(ROWS + 1);
  localparam int EFW      = $clog2(EVENTS + 1);
  localparam int WF_DEPTH = ROWS << CW;

  ssr_state_t state;
  ssr_state_t state_next;

  logic [7:0]    threshold;
  logic [15:0]   holdoff;

  logic [RW-1:0] row_head;
  logic [FW-1:0] row_fill;
  logic [31:0]   sweep_total;

  logic [7:0]    wf_mem  [WF_DEPTH];
  logic [31:0]   occ_mem [CHANNELS];
  logic [CHANNELS-1:0] occ_valid;

  logic          acc;
  logic          exec_fire;
  op_t           op;
  logic          ch_ok;
  logic [CW-1:0] ch_idx;
  logic [RW:0]   wf_sum;
  logic [RW-1:0] wf_row;

  op_t           op_q;
  logic [CW-1:0] ch_q;
  logic          ch_ok_q;
  logic [7:0]    lvl_q;
  logic          wf_hit;
  logic [7:0]    wf_rd;
  logic          occ_hit;
  logic [31:0]   occ_rd;
  logic [31:0]   occ_cur;
  logic [32:0]   occ_sum;
  logic [31:0]   occ_sat;
  logic [31:0]   read_value_next;
  logic          out_full;

  ev_cmd_t        ev_cmd;
  ev_res_t        ev_res;
  logic [EFW-1:0] ev_fill;

  assign acc    = req.valid && req.ready;
  assign op     = op_t'(req.operation);
  assign ch_ok  = 32'(req.channel) < CHANNELS;
  assign ch_idx = CW'(req.channel);

  assign wf_sum = {1'b0, row_head} + (RW+1)'(ROWS - 1) - {1'b0, RW'(req.age)};
  assign wf_row = (wf_sum >= (RW+1)'(ROWS)) ? RW'(wf_sum - (RW+1)'(ROWS)) : RW'(wf_sum);

  // Configuration
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      holdoff   <= HOLDOFF_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.addr))
        CFG_THRESHOLD: threshold <= cfg.data[7:0];
        CFG_HOLDOFF:   holdoff   <= cfg.data;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (acc) state_next = ST_EXEC;
      ST_EXEC: if (exec_fire) state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE) && !rst;
    exec_fire = (state == ST_EXEC) && (!out_full || rsp.ready);
  end

  // Waterfall memory
  always_ff @(posedge clk) begin
    if (acc && (op == OP_SAMPLE) && ch_ok) begin
      wf_mem[{row_head, ch_idx}] <= req.level;
    end
    if (acc) begin
      wf_rd <= wf_mem[{wf_row, ch_idx}];
    end
  end

  // Occupancy memory: read at accept, write back in the execute state.
  assign occ_cur = occ_hit ? occ_rd : '0;
  assign occ_sum = {1'b0, occ_cur} + 33'(lvl_q);
  assign occ_sat = occ_sum[32] ? '1 : occ_sum[31:0];

  always_ff @(posedge clk) begin
    if (acc) begin
      occ_rd <= occ_mem[ch_idx];
    end
    if (exec_fire && (op_q == OP_SAMPLE) && ch_ok_q) begin
      occ_mem[ch_q] <= occ_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_q    <= op;
      ch_q    <= ch_idx;
      ch_ok_q <= ch_ok;
      lvl_q   <= req.level;
      wf_hit  <= ch_ok && (32'(req.age) < 32'(row_fill));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ_valid   <= '0;
      occ_hit     <= 1'b0;
      row_head    <= '0;
      row_fill    <= '0;
      sweep_total <= '0;
    end else if (acc) begin
      occ_hit <= ch_ok && occ_valid[ch_idx];
      case (op)
        OP_SWEEP_END: begin
          row_head    <= (row_head == RW'(ROWS - 1)) ? '0 : row_head + RW'(1);
          sweep_total <= sweep_total + 32'd1;
          if (row_fill < FW'(ROWS)) begin
            row_fill <= row_fill + FW'(1);
          end
        end
        OP_RESET_SURVEY: begin
          occ_valid   <= '0;
          sweep_total <= '0;
        end
        default: ;
      endcase
    end else if (exec_fire && (op_q == OP_SAMPLE) && ch_ok_q) begin
      occ_valid[ch_q] <= 1'b1;
    end
  end

  // Event ring
  always_comb begin
    ev_cmd.take      = acc;
    ev_cmd.sweep     = (op == OP_SWEEP_END);
    ev_cmd.clear     = (op == OP_CLEAR_EVENTS);
    ev_cmd.read      = (op == OP_READ_EVENT);
    ev_cmd.stamp     = req.timestamp_ms;
    ev_cmd.chan      = req.peak_channel;
    ev_cmd.lvl       = req.peak_level;
    ev_cmd.age       = req.age;
    ev_cmd.threshold = threshold;
    ev_cmd.holdoff   = holdoff;
  end

  ssr_event_ring #(
    .EVENTS (EVENTS)
  ) u_event_ring (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ev_cmd),
    .res  (ev_res),
    .fill (ev_fill)
  );

  // Result word
  always_comb begin
    case (op_q)
      OP_READ_OCC:   read_value_next = ch_ok_q ? occ_cur : '0;
      OP_READ_WF:    read_value_next = wf_hit ? 32'(wf_rd) : '0;
      OP_READ_EVENT: read_value_next = ev_res.hit ? ev_res.rec.stamp : '0;
      default:       read_value_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (exec_fire) begin
      out_full <= 1'b1;
    end else if (rsp.ready) begin
      out_full <= 1'b0;
    end
  end

  assign rsp.valid = out_full;

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      rsp.read_value    <= read_value_next;
      rsp.event_channel <= ev_res.rec.chan;
      rsp.event_level   <= ev_res.rec.lvl;
      rsp.event_logged  <= ev_res.logged;
      rsp.sweeps_done   <= sweep_total;
      rsp.rows_filled   <= 7'(row_fill);
      rsp.events_held   <= 5'(ev_fill);
    end
  end

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("word accepted while another is in its second cycle");

  a_row_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(row_fill) <= ROWS)
    else $error("waterfall row count beyond ring depth");

  a_sweep_count: assert property (@(posedge clk) disable iff (rst)
    acc && (op == OP_SWEEP_END) |=> sweep_total == $past(sweep_total) + 32'd1)
    else $error("sweep count did not advance on sweep end");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> rsp.valid)
    else $error("finished word not presented on the result channel");
`endif

endmodule
